[rtl/xyvls_pkg.sv]
package xyvls_pkg;

   // fixed field widths
   localparam int COORD_BITS      = 14;
   localparam int XYVLS_FRAC_BITS = 16;
   localparam int STEP_W          = 20;
   localparam int HALF_W          = 14;
   localparam int SAMPLE_W        = 16;

   // csr port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 20;

   localparam logic [CSR_ADDR_W-1:0] CSR_STEP_SIZE   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_HALF_EXTENT = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_INVERT_X    = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_INVERT_Y    = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_SWAP_XY     = 3'd4;

   localparam logic [STEP_W-1:0] STEP_SIZE_RST   = 20'd26214;
   localparam logic [HALF_W-1:0] HALF_EXTENT_RST = 14'd600;

   // command codes
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   // arithmetic widths
   localparam int LEN_W = COORD_BITS + 1;
   localparam int SQ_W  = 2 * COORD_BITS + 2;
   localparam int NUM_W = COORD_BITS + STEP_W + 1;
   localparam int DEN_W = (LEN_W > HALF_W) ? LEN_W : HALF_W;
   localparam int QUO_W = STEP_W + 1;
   localparam int MAG_W = SAMPLE_W - 1;

   typedef struct packed {
      logic                  func;
      logic [COORD_BITS-1:0] start_x;
      logic [COORD_BITS-1:0] start_y;
      logic [COORD_BITS-1:0] end_x;
      logic [COORD_BITS-1:0] end_y;
      logic                  double_speed;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] point_x;
      logic signed [SAMPLE_W-1:0] point_y;
      logic                       point_valid;
      logic                       last;
   } rsp_type;

   typedef struct packed {
      logic                  is_load;
      logic [COORD_BITS-1:0] sx;
      logic [COORD_BITS-1:0] sy;
      logic [COORD_BITS-1:0] ex;
      logic [COORD_BITS-1:0] ey;
      logic                  dbl;
   } cmd_type;

   typedef struct packed {
      logic [STEP_W-1:0] step_size;
      logic [HALF_W-1:0] half_extent;
      logic              invert_x;
      logic              invert_y;
      logic              swap_xy;
   } csr_type;

endpackage

[rtl/xyvls_front.sv]
module xyvls_front
   import xyvls_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    q_valid,
   input  logic    q_ready,
   output cmd_type q_data
);

   // two-entry command queue in front of the sequencer
   cmd_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push_ok, pop_ok;
   cmd_type    cmd;

   assign req_full = (cnt_ff == 2'd2);
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_data   = mem_ff[rd_ptr_ff];
   assign push_ok  = req_push && !req_full;
   assign pop_ok   = q_valid && q_ready;

   always_comb begin
      cmd.is_load = (req_data.func == FUNC_LOAD);
      cmd.sx      = req_data.start_x;
      cmd.sy      = req_data.start_y;
      cmd.ex      = req_data.end_x;
      cmd.ey      = req_data.end_y;
      cmd.dbl     = req_data.double_speed;
      wr_ptr_in   = push_ok ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in   = pop_ok ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in      = cnt_ff + {1'b0, push_ok} - {1'b0, pop_ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

[rtl/xyvls_div.sv]
module xyvls_div
   import xyvls_pkg::*;
#(
   parameter int NW = NUM_W,
   parameter int DW = DEN_W,
   parameter int QW = QUO_W
)(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          done,
   output logic [QW-1:0] quo
);

   // restoring divider, one quotient bit per cycle; quotient must fit QW bits
   localparam int ACC_W = (NW > DW + QW) ? NW : DW + QW;
   localparam int CNT_W = $clog2(QW);

   logic [ACC_W-1:0] rem_ff, rem_in;
   logic [ACC_W-1:0] sh_ff, sh_in;
   logic [QW-1:0]    quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             ge;

   assign done = done_ff;
   assign quo  = quo_ff;
   assign ge   = (rem_ff >= sh_ff);

   always_comb begin
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = ACC_W'(num);
         sh_in   = ACC_W'(den) << (QW - 1);
         quo_in  = '0;
         cnt_in  = CNT_W'(QW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? rem_ff - sh_ff : rem_ff;
         sh_in  = sh_ff >> 1;
         quo_in = {quo_ff[QW-2:0], ge};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

endmodule

[rtl/xyvls_back.sv]
module xyvls_back
   import xyvls_pkg::*;
#(
   parameter int FRAC_BITS = XYVLS_FRAC_BITS
)(
   input  logic    clock,
   input  logic    reset,
   input  csr_type csr,
   input  logic    q_valid,
   output logic    q_ready,
   input  cmd_type q_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   localparam int POS_W = COORD_BITS + FRAC_BITS + 4;
   localparam int D_W   = POS_W + 1;
   localparam int P15_W = D_W + 15;
   localparam int INC_W = QUO_W + 1;
   localparam int PAD_W = POS_W - COORD_BITS - FRAC_BITS;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SQ   = 4'd1;
   localparam logic [3:0] S_ROOT = 4'd2;
   localparam logic [3:0] S_LEN  = 4'd3;
   localparam logic [3:0] S_DXG  = 4'd4;
   localparam logic [3:0] S_DXW  = 4'd5;
   localparam logic [3:0] S_DYG  = 4'd6;
   localparam logic [3:0] S_DYW  = 4'd7;
   localparam logic [3:0] S_TCHK = 4'd8;
   localparam logic [3:0] S_NA   = 4'd9;
   localparam logic [3:0] S_NB   = 4'd10;
   localparam logic [3:0] S_NC   = 4'd11;
   localparam logic [3:0] S_NW   = 4'd12;
   localparam logic [3:0] S_ADV  = 4'd13;
   localparam logic [3:0] S_MORE = 4'd14;
   localparam logic [3:0] S_OUT  = 4'd15;

   function automatic logic axis_open(logic signed [POS_W-1:0] p,
                                      logic [COORD_BITS-1:0] tgt,
                                      logic signed [INC_W-1:0] inc);
      logic signed [POS_W-1:0] t;
      t = $signed({{PAD_W{1'b0}}, tgt, {FRAC_BITS{1'b0}}});
      return (inc[INC_W-1] && (p > t)) ||
             (!inc[INC_W-1] && (inc != '0) && (p < t));
   endfunction

   logic [3:0]                state_ff, state_in;
   logic signed [POS_W-1:0]   pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic signed [INC_W-1:0]   inc_x_ff, inc_x_in, inc_y_ff, inc_y_in;
   logic [COORD_BITS-1:0]     tgt_x_ff, tgt_x_in, tgt_y_ff, tgt_y_in;
   logic                      active_ff, active_in;
   logic [COORD_BITS-1:0]     mag_x_ff, mag_x_in, mag_y_ff, mag_y_in;
   logic                      neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic                      dbl_ff, dbl_in;
   logic [SQ_W-1:0]           sq_v_ff, sq_v_in, sq_r_ff, sq_r_in, sq_bit_ff, sq_bit_in;
   logic [NUM_W-1:0]          prod_x_ff, prod_x_in, prod_y_ff, prod_y_in;
   logic [LEN_W-1:0]          len_ff, len_in;
   logic                      axis_ff, axis_in;
   logic signed [D_W-1:0]     d_ff, d_in;
   logic [NUM_W-1:0]          num_ff, num_in;
   logic                      neg_ff, neg_in;
   logic signed [SAMPLE_W-1:0] nx_ff, nx_in, ny_ff, ny_in;
   rsp_type                   res_ff, res_in;
   logic                      out_valid_ff, out_valid_in;
   rsp_type                   out_data_ff, out_data_in;

   logic                      div_start, div_done;
   logic [NUM_W-1:0]          div_num;
   logic [DEN_W-1:0]          div_den;
   logic [QUO_W-1:0]          div_quo;

   logic signed [LEN_W-1:0]   dx, dy;
   logic [SQ_W-1:0]           root_sum;
   logic [HALF_W-1:0]         he_eff;
   logic signed [D_W-1:0]     h_val;
   logic [D_W-1:0]            abs_d;
   logic [P15_W-1:0]          p15;
   logic [MAG_W-1:0]          m_val;
   logic                      m_store;
   logic signed [SAMPLE_W-1:0] sample;
   logic                      more;

   xyvls_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign q_ready   = (state_ff == S_IDLE);
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      dx       = $signed({1'b0, q_data.ex}) - $signed({1'b0, q_data.sx});
      dy       = $signed({1'b0, q_data.ey}) - $signed({1'b0, q_data.sy});
      root_sum = sq_r_ff + sq_bit_ff;
      he_eff   = (csr.half_extent == '0) ? HALF_W'(1) : csr.half_extent;
      h_val    = $signed({{(D_W - HALF_W - FRAC_BITS){1'b0}}, he_eff, {FRAC_BITS{1'b0}}});
      abs_d    = d_ff[D_W-1] ? D_W'(-d_ff) : D_W'(d_ff);
      p15      = (P15_W'(abs_d) << 15) - P15_W'(abs_d);
      sample   = neg_ff ? -$signed({1'b0, m_val}) : $signed({1'b0, m_val});
      more     = axis_open(pos_x_ff, tgt_x_ff, inc_x_ff) ||
                 axis_open(pos_y_ff, tgt_y_ff, inc_y_ff);

      state_in   = state_ff;
      pos_x_in   = pos_x_ff;
      pos_y_in   = pos_y_ff;
      inc_x_in   = inc_x_ff;
      inc_y_in   = inc_y_ff;
      tgt_x_in   = tgt_x_ff;
      tgt_y_in   = tgt_y_ff;
      active_in  = active_ff;
      mag_x_in   = mag_x_ff;
      mag_y_in   = mag_y_ff;
      neg_x_in   = neg_x_ff;
      neg_y_in   = neg_y_ff;
      dbl_in     = dbl_ff;
      sq_v_in    = sq_v_ff;
      sq_r_in    = sq_r_ff;
      sq_bit_in  = sq_bit_ff;
      prod_x_in  = prod_x_ff;
      prod_y_in  = prod_y_ff;
      len_in     = len_ff;
      axis_in    = axis_ff;
      d_in       = d_ff;
      num_in     = num_ff;
      neg_in     = neg_ff;
      nx_in      = nx_ff;
      ny_in      = ny_ff;
      res_in     = res_ff;
      out_data_in  = out_data_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      div_start  = 1'b0;
      div_num    = prod_x_ff;
      div_den    = DEN_W'(len_ff);
      m_val      = div_quo[MAG_W-1:0];
      m_store    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               if (q_data.is_load) begin
                  tgt_x_in = q_data.ex;
                  tgt_y_in = q_data.ey;
                  pos_x_in = $signed({{PAD_W{1'b0}}, q_data.sx, {FRAC_BITS{1'b0}}});
                  pos_y_in = $signed({{PAD_W{1'b0}}, q_data.sy, {FRAC_BITS{1'b0}}});
                  neg_x_in = dx[LEN_W-1];
                  neg_y_in = dy[LEN_W-1];
                  mag_x_in = dx[LEN_W-1] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
                  mag_y_in = dy[LEN_W-1] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
                  dbl_in   = q_data.dbl;
                  state_in = S_SQ;
               end else begin
                  state_in = S_TCHK;
               end
            end
         end
         S_SQ: begin
            sq_v_in   = SQ_W'(mag_x_ff * mag_x_ff) + SQ_W'(mag_y_ff * mag_y_ff);
            sq_r_in   = '0;
            sq_bit_in = SQ_W'(1) << (SQ_W - 2);
            state_in  = S_ROOT;
         end
         S_ROOT: begin
            if (sq_v_ff >= root_sum) begin
               sq_v_in = sq_v_ff - root_sum;
               sq_r_in = (sq_r_ff >> 1) + sq_bit_ff;
            end else begin
               sq_r_in = sq_r_ff >> 1;
            end
            sq_bit_in = sq_bit_ff >> 2;
            if (sq_bit_ff[0]) begin
               state_in = S_LEN;
            end
         end
         S_LEN: begin
            len_in    = sq_r_ff[LEN_W-1:0];
            prod_x_in = NUM_W'(mag_x_ff * csr.step_size) << dbl_ff;
            prod_y_in = NUM_W'(mag_y_ff * csr.step_size) << dbl_ff;
            if (sq_r_ff == '0) begin
               inc_x_in  = '0;
               inc_y_in  = '0;
               active_in = 1'b0;
               state_in  = S_IDLE;
            end else begin
               state_in = S_DXG;
            end
         end
         S_DXG: begin
            div_start = 1'b1;
            state_in  = S_DXW;
         end
         S_DXW: begin
            if (div_done) begin
               inc_x_in = neg_x_ff ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
               state_in = S_DYG;
            end
         end
         S_DYG: begin
            div_start = 1'b1;
            div_num   = prod_y_ff;
            state_in  = S_DYW;
         end
         S_DYW: begin
            if (div_done) begin
               inc_y_in  = neg_y_ff ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
               active_in = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_TCHK: begin
            if (active_ff && more) begin
               axis_in  = 1'b0;
               state_in = S_NA;
            end else begin
               active_in         = 1'b0;
               res_in.point_x     = '0;
               res_in.point_y     = '0;
               res_in.point_valid = 1'b0;
               res_in.last        = 1'b1;
               state_in          = S_OUT;
            end
         end
         S_NA: begin
            d_in     = (axis_ff ? D_W'(pos_y_ff) : D_W'(pos_x_ff)) - h_val;
            state_in = S_NB;
         end
         S_NB: begin
            neg_in   = d_ff[D_W-1] ^ (axis_ff ? csr.invert_y : csr.invert_x);
            num_in   = NUM_W'(p15 >> FRAC_BITS);
            state_in = S_NC;
         end
         S_NC: begin
            if (num_ff >= NUM_W'({he_eff, 15'd0})) begin
               m_val   = {MAG_W{1'b1}};
               m_store = 1'b1;
            end else begin
               div_start = 1'b1;
               div_num   = num_ff;
               div_den   = DEN_W'(he_eff);
               state_in  = S_NW;
            end
         end
         S_NW: begin
            m_store = div_done;
         end
         S_ADV: begin
            pos_x_in = pos_x_ff + POS_W'(inc_x_ff);
            pos_y_in = pos_y_ff + POS_W'(inc_y_ff);
            state_in = S_MORE;
         end
         S_MORE: begin
            active_in          = more;
            res_in.point_x     = csr.swap_xy ? ny_ff : nx_ff;
            res_in.point_y     = csr.swap_xy ? nx_ff : ny_ff;
            res_in.point_valid = 1'b1;
            res_in.last        = !more;
            state_in           = S_OUT;
         end
         S_OUT: begin
            if (!out_valid_ff || rsp_pop) begin
               out_data_in  = res_ff;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // one axis sample finished: keep it, go on to the other axis or advance
      if (m_store) begin
         if (!axis_ff) begin
            nx_in    = sample;
            axis_in  = 1'b1;
            state_in = S_NA;
         end else begin
            ny_in    = sample;
            state_in = S_ADV;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
      pos_x_ff    <= pos_x_in;
      pos_y_ff    <= pos_y_in;
      inc_x_ff    <= inc_x_in;
      inc_y_ff    <= inc_y_in;
      tgt_x_ff    <= tgt_x_in;
      tgt_y_ff    <= tgt_y_in;
      mag_x_ff    <= mag_x_in;
      mag_y_ff    <= mag_y_in;
      neg_x_ff    <= neg_x_in;
      neg_y_ff    <= neg_y_in;
      dbl_ff      <= dbl_in;
      sq_v_ff     <= sq_v_in;
      sq_r_ff     <= sq_r_in;
      sq_bit_ff   <= sq_bit_in;
      prod_x_ff   <= prod_x_in;
      prod_y_ff   <= prod_y_in;
      len_ff      <= len_in;
      axis_ff     <= axis_in;
      d_ff        <= d_in;
      num_ff      <= num_in;
      neg_ff      <= neg_in;
      nx_ff       <= nx_in;
      ny_ff       <= ny_in;
      res_ff      <= res_in;
      out_data_ff <= out_data_in;
   end

endmodule

[rtl/xy_vector_line_stepper_top.sv]
// Sequencing: a load beat runs a 15-step square root, then two divides in the
//   sequencer; a tick beat runs up to two divides (the sample scaling) before its
//   result reaches the rsp side.
// Throughput: one beat at a time in the sequencer; the divider is shared by loads and ticks.
// Reset: synchronous, active high; clears queues, segment state and csrs to defaults.
module xy_vector_line_stepper_top
   import xyvls_pkg::*;
#(
   parameter int FRAC_BITS = XYVLS_FRAC_BITS
)(
   input  logic                  clock,
   input  logic                  reset,
   // request queue side
   input  logic                  req_push,
   output logic                  req_full,
   input  req_type               req_data,
   // result queue side
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output rsp_type               rsp_data,
   // csr write port
   input  logic                  csr_wen,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // csr file; the host must write it only while nothing is in flight; the block does not enforce it
   csr_type csr_ff, csr_in;

   // front -> back command queue handshake
   logic    q_valid;
   logic    q_ready;
   cmd_type q_data;

   always_comb begin
      csr_in = csr_ff;
      if (csr_wen) begin
         unique case (csr_addr)
            CSR_STEP_SIZE:   csr_in.step_size   = csr_wdata[STEP_W-1:0];
            CSR_HALF_EXTENT: csr_in.half_extent = csr_wdata[HALF_W-1:0];
            CSR_INVERT_X:    csr_in.invert_x    = csr_wdata[0];
            CSR_INVERT_Y:    csr_in.invert_y    = csr_wdata[0];
            CSR_SWAP_XY:     csr_in.swap_xy     = csr_wdata[0];
            default:         csr_in             = csr_ff;  // unmapped index, dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.step_size   <= STEP_SIZE_RST;
         csr_ff.half_extent <= HALF_EXTENT_RST;
         csr_ff.invert_x    <= 1'b0;
         csr_ff.invert_y    <= 1'b0;
         csr_ff.swap_xy     <= 1'b1;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // front: takes beats, tags load vs tick, queues them
   xyvls_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_data   (q_data)
   );

   // back: segment setup, point stepping, sample scaling, output register
   xyvls_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_data    (q_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

[rtl/xyvls_checker.sv]
module xyvls_checker
   import xyvls_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_full,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input rsp_type rsp_data
);

   // after reset both queues are empty
   assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // a waiting beat holds until popped
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("result beat changed while waiting");

   // a tick without a point ends the segment and carries zero samples
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_data.point_valid |->
         rsp_data.last && rsp_data.point_x == '0 && rsp_data.point_y == '0)
      else $error("empty tick result malformed");

   // samples saturate symmetrically, never at the most negative code
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.point_valid |->
         rsp_data.point_x != 16'sh8000 && rsp_data.point_y != 16'sh8000)
      else $error("sample out of full-scale range");

endmodule

bind xy_vector_line_stepper_top xyvls_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

[tb/xyvls_checker.sv]
module xyvls_tb_checker
   import xyvls_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  logic                  req_full,
   input  req_type               req_data,
   input  logic                  rsp_empty,
   input  logic                  rsp_pop,
   input  rsp_type               rsp_data,
   input  logic                  csr_wen,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending
);

   localparam longint ONE = longint'(1) << XYVLS_FRAC_BITS;

   logic [STEP_W-1:0]     step_size;
   logic [HALF_W-1:0]     half_extent;
   logic                  invert_x, invert_y, swap_xy;
   longint                pos_x, pos_y, inc_x, inc_y;
   logic [COORD_BITS-1:0] target_x, target_y;
   bit                    seg_on;
   rsp_type               point_queue[$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   function automatic longint floor_sqrt(input longint v);
      longint r, b;
      r = 0;
      b = longint'(1) << 62;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >>> 1) + b;
         end else begin
            r = r >>> 1;
         end
         b = b >>> 2;
      end
      return r;
   endfunction

   function automatic longint step_of(input longint d, input longint len, input bit dbl);
      longint m;
      m = (d < 0 ? -d : d) * longint'(step_size) * (dbl ? 2 : 1) / len;
      return d < 0 ? -m : m;
   endfunction

   function automatic bit axis_open(input longint p, input logic [COORD_BITS-1:0] t,
                                    input longint inc);
      longint tf;
      tf = longint'(t) * ONE;
      return (inc < 0 && p > tf) || (inc > 0 && p < tf);
   endfunction

   function automatic bit still_open();
      return axis_open(pos_x, target_x, inc_x) || axis_open(pos_y, target_y, inc_y);
   endfunction

   function automatic longint to_sample(input longint p, input bit neg);
      longint h, d, m;
      bit below;
      h = longint'(half_extent == 0 ? 1 : half_extent) * ONE;
      d = p - h;
      m = (d < 0 ? -d : d) * 32767 / h;
      below = (d < 0) != neg;
      if (m > 32767) m = 32767;
      return below ? -m : m;
   endfunction

   task automatic predict(input req_type r);
      longint dx, dy, len, nx, ny;
      rsp_type p;
      if (r.func == FUNC_LOAD) begin
         dx = longint'(r.end_x) - longint'(r.start_x);
         dy = longint'(r.end_y) - longint'(r.start_y);
         len = floor_sqrt(dx * dx + dy * dy);
         target_x = r.end_x;
         target_y = r.end_y;
         pos_x = longint'(r.start_x) * ONE;
         pos_y = longint'(r.start_y) * ONE;
         if (len == 0) begin
            inc_x = 0;
            inc_y = 0;
            seg_on = 0;
         end else begin
            inc_x = step_of(dx, len, r.double_speed);
            inc_y = step_of(dy, len, r.double_speed);
            seg_on = 1;
         end
         return;
      end
      if (!seg_on || !still_open()) begin
         // idle tick: blank sample, flagged last
         seg_on = 0;
         p = '0;
         p.last = 1'b1;
      end else begin
         nx = to_sample(pos_x, invert_x);
         ny = to_sample(pos_y, invert_y);
         p.point_x = swap_xy ? ny[SAMPLE_W-1:0] : nx[SAMPLE_W-1:0];
         p.point_y = swap_xy ? nx[SAMPLE_W-1:0] : ny[SAMPLE_W-1:0];
         pos_x += inc_x;
         pos_y += inc_y;
         p.point_valid = 1'b1;
         p.last = !still_open();
         if (p.last) seg_on = 0;
      end
      point_queue.insert(point_queue.size(), p);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         step_size   = STEP_SIZE_RST;
         half_extent = HALF_EXTENT_RST;
         invert_x    = 0;
         invert_y    = 0;
         swap_xy     = 1;
         pos_x = 0; pos_y = 0; inc_x = 0; inc_y = 0;
         target_x = '0; target_y = '0;
         seg_on = 0;
         point_queue.delete();
      end else begin
         if (csr_wen) begin
            case (csr_addr)
               CSR_STEP_SIZE:   step_size   = csr_wdata[STEP_W-1:0];
               CSR_HALF_EXTENT: half_extent = csr_wdata[HALF_W-1:0];
               CSR_INVERT_X:    invert_x    = csr_wdata[0];
               CSR_INVERT_Y:    invert_y    = csr_wdata[0];
               CSR_SWAP_XY:     swap_xy     = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_pop && !rsp_empty) begin
            if (point_queue.size() == 0) begin
               report_mismatch("result beat with nothing expected");
            end else begin
               rsp_type e;
               e = point_queue.pop_front();
               if (rsp_data.point_x !== e.point_x)
                  report_mismatch($sformatf("point_x %0d, want %0d",
                                            rsp_data.point_x, e.point_x));
               if (rsp_data.point_y !== e.point_y)
                  report_mismatch($sformatf("point_y %0d, want %0d",
                                            rsp_data.point_y, e.point_y));
               if (rsp_data.point_valid !== e.point_valid)
                  report_mismatch($sformatf("point_valid %b, want %b",
                                            rsp_data.point_valid, e.point_valid));
               if (rsp_data.last !== e.last)
                  report_mismatch($sformatf("last %b, want %b", rsp_data.last, e.last));
            end
         end
         if (req_push && !req_full) predict(req_data);
      end
      pending = point_queue.size();
   end

endmodule

[tb/tb_top.sv]
module tb_top
   import xyvls_pkg::*;
;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_push = 0;
   logic                  req_full;
   req_type               req_data = '0;
   logic                  rsp_empty;
   logic                  rsp_pop = 0;
   rsp_type               rsp_data;
   logic                  csr_wen = 0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int fail_count, pending;
   int hold_left = 0;   // receiver hold-off, in cycles
   int burst_left = 0;  // beats left in the current sender burst
   int sent = 0;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   xy_vector_line_stepper_top DUT (
      .clock, .reset,
      .req_push, .req_full, .req_data,
      .rsp_empty, .rsp_pop, .rsp_data,
      .csr_wen, .csr_addr, .csr_wdata
   );

   xyvls_tb_checker u_checker (
      .clock, .reset,
      .req_push, .req_full, .req_data,
      .rsp_empty, .rsp_pop, .rsp_data,
      .csr_wen, .csr_addr, .csr_wdata,
      .fail_count, .pending
   );

   // Run limit: far beyond the slowest correct run (~1300 beats plus stalls and
   // settle gaps).
   initial begin
      #4000000;
      $display("status: fail");
      $finish;
   end

   // Receiver: random stalls, runs of back-to-back pops, and a long hold-off
   // when the stimulus asks for one.
   initial begin
      int free_run;
      free_run = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_pop = 0;
            hold_left--;
         end else if (free_run > 0) begin
            rsp_pop = 1;
            free_run--;
         end else begin
            rsp_pop = ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 40) == 0) free_run = $urandom_range(20, 120);
         end
      end
   end

   function automatic logic [COORD_BITS-1:0] any_coord();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         default: return COORD_BITS'($urandom_range(0, (1 << COORD_BITS) - 1));
      endcase
   endfunction

   function automatic req_type load_beat(input int sx, input int sy, input int ex,
                                         input int ey, input bit dbl);
      req_type r;
      r.func = FUNC_LOAD;
      r.start_x = COORD_BITS'(sx); r.start_y = COORD_BITS'(sy);
      r.end_x = COORD_BITS'(ex);   r.end_y = COORD_BITS'(ey);
      r.double_speed = dbl;
      return r;
   endfunction

   // tick: unused fields carry random junk
   function automatic req_type tick_beat();
      req_type r;
      r = load_beat(any_coord(), any_coord(), any_coord(), any_coord(),
                    1'($urandom_range(0, 1)));
      r.func = FUNC_TICK;
      return r;
   endfunction

   // end coordinate near a start, clamped into range
   function automatic int near(input int c);
      int v;
      v = c + $urandom_range(0, 80) - 40;
      if (v < 0) v = 0;
      if (v > (1 << COORD_BITS) - 1) v = (1 << COORD_BITS) - 1;
      return v;
   endfunction

   // Called at a falling edge; push stays high across a burst.
   task automatic send(input req_type r);
      req_push = 1;
      req_data = r;
      do @(posedge clock); while (req_full);
      sent++;
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_push = 0;
         if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = $urandom_range(0, 20);
      end
   endtask

   task automatic ticks(input int n);
      repeat (n) send(tick_beat());
   endtask

   // Drain and let the sequencer finish a trailing load before touching csrs.
   task automatic settle();
      req_push = 0;
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] a, input int d);
      csr_wen = 1;
      csr_addr = a;
      csr_wdata = CSR_DATA_W'(d);
      @(negedge clock);
      csr_wen = 0;
   endtask

   task automatic setup(input int stp, input int half, input bit ix, input bit iy,
                        input bit sw);
      write_reg(CSR_STEP_SIZE, stp);
      write_reg(CSR_HALF_EXTENT, half);
      write_reg(CSR_INVERT_X, ix);
      write_reg(CSR_INVERT_Y, iy);
      write_reg(CSR_SWAP_XY, sw);
   endtask

   initial begin
      int stp, half, n, sx, sy;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed, reset settings
      ticks(1);                                   // tick with no segment
      send(load_beat(100, 200, 100, 200, 0));     // zero length
      ticks(2);
      send(load_beat(0, 0, 16383, 16383, 1));     // full-range diagonal
      ticks(3);
      send(load_beat(16383, 16383, 16380, 16381, 0));  // negative direction, ends
      ticks(12);
      send(load_beat(1200, 0, 1200, 3, 0));       // vertical, at the edge of full scale
      ticks(10);
      settle();

      // zero steps: one axis, then both
      setup(1, 1, 1, 0, 0);
      send(load_beat(50, 50, 51, 70, 0));
      ticks(2);
      send(load_beat(10, 10, 13, 13, 0));
      ticks(2);
      settle();

      // largest step the bench uses, double speed, full-scale mapping
      setup(524288, 16383, 0, 1, 1);
      send(load_beat(0, 16383, 40, 16300, 1));
      ticks(6);
      settle();

      // random phases
      for (int p = 0; p < 8; p++) begin
         case (p)
            0:       stp = 1;
            1:       stp = 524288;
            default: stp = $urandom_range(1, 524288);
         endcase
         case (p)
            2:       half = 1;
            3:       half = 16383;
            default: half = $urandom_range(1, 16383);
         endcase
         setup(stp, half, p[0], p[1], p[2]);
         n = 0;
         while (n < 160) begin
            if (p == 1 && n == 20) hold_left = 400;   // fill the block, stall the input
            if (p == 3 && n == 80) begin              // sender waits for full drain
               req_push = 0;
               while (pending != 0) @(posedge clock);
               @(negedge clock);
            end
            case ($urandom_range(0, 9))
               0: begin                                // noise: stray ticks
                  ticks(1);
                  n += 1;
               end
               1: begin                                // broken: load, no ticks
                  send(load_beat(any_coord(), any_coord(), any_coord(), any_coord(),
                                 1'($urandom_range(0, 1))));
                  n += 1;
               end
               default: begin
                  sx = any_coord();
                  sy = any_coord();
                  if ($urandom_range(0, 3) == 0)
                     send(load_beat(sx, sy, any_coord(), any_coord(),
                                    1'($urandom_range(0, 1))));
                  else
                     send(load_beat(sx, sy, near(sx), near(sy), 1'($urandom_range(0, 1))));
                  stp = $urandom_range(1, 25);
                  ticks(stp);
                  n += stp + 1;
               end
            endcase
         end
         settle();
      end

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
